// ===== hdl/cdo_pkg.sv =====
// cdo_pkg: types, command codes, step program and month tables for the
// calendar date offset unit; no dependencies
`default_nettype none

package cdo_pkg;

    // fixed widths of the beat fields
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int VALUE_W = 16;
    localparam int OFF_W   = 16;
    localparam int YOUT_W  = 16;

    // signed day accumulator: stored day plus the widest offset, with sign
    localparam int ACC_W = 18;

    localparam int MONTHS     = 12;
    localparam int YEAR_DAYS  = 365;
    localparam int RESET_YEAR = 2000;

    // command codes
    localparam logic [2:0] CMD_SET_MONTH = 3'd0;
    localparam logic [2:0] CMD_SET_DAY   = 3'd1;
    localparam logic [2:0] CMD_SET_YEAR  = 3'd2;
    localparam logic [2:0] CMD_QUERY     = 3'd3;
    localparam logic [2:0] CMD_MOVE      = 3'd4;

    // step operations of the sequencer
    localparam logic [2:0] OP_YEAR_UP = 3'd0;
    localparam logic [2:0] OP_MON_UP  = 3'd1;
    localparam logic [2:0] OP_YEAR_DN = 3'd2;
    localparam logic [2:0] OP_MON_DN  = 3'd3;
    localparam logic [2:0] OP_DONE    = 3'd4;

    // program addresses
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_YEAR_UP = 3'd0;
    localparam logic [PC_W-1:0] PC_MON_UP  = 3'd1;
    localparam logic [PC_W-1:0] PC_YEAR_DN = 3'd2;
    localparam logic [PC_W-1:0] PC_MON_DN  = 3'd3;
    localparam logic [PC_W-1:0] PC_DONE    = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic [VALUE_W-1:0] set_value;
        logic signed [OFF_W-1:0] day_offset;
    } t_in_beat;

    typedef struct packed {
        logic [MONTH_W-1:0] stored_month;
        logic [DAY_W-1:0]   stored_day;
        logic [YOUT_W-1:0]  stored_year;
        logic [MONTH_W-1:0] other_month;
        logic [DAY_W-1:0]   other_day;
        logic [YOUT_W-1:0]  other_year;
    } t_out_beat;

    // control word: operation, target when its test holds, target otherwise
    typedef struct packed {
        logic [2:0]      op;
        logic [PC_W-1:0] jmp;
        logic [PC_W-1:0] nxt;
    } t_uword;

    // step program
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_YEAR_UP: w = '{op: OP_YEAR_UP, jmp: PC_YEAR_UP, nxt: PC_MON_UP};
            PC_MON_UP:  w = '{op: OP_MON_UP,  jmp: PC_MON_UP,  nxt: PC_YEAR_DN};
            PC_YEAR_DN: w = '{op: OP_YEAR_DN, jmp: PC_YEAR_DN, nxt: PC_MON_DN};
            PC_MON_DN:  w = '{op: OP_MON_DN,  jmp: PC_MON_DN,  nxt: PC_DONE};
            PC_DONE:    w = '{op: OP_DONE,    jmp: PC_DONE,    nxt: PC_DONE};
            default:    w = '{op: OP_DONE,    jmp: PC_DONE,    nxt: PC_DONE};
        endcase
        return w;
    endfunction

    // days in a month, no leap years; out of range reads as 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // month before m, january wraps to december
    function automatic logic [MONTH_W-1:0] prev_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] p;
        if (m == 4'd1) begin
            p = MONTH_W'(MONTHS);
        end else begin
            p = m - 4'd1;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/calendar_date_offset_unit.sv =====
// calendar_date_offset_unit: date store with set, offset query and move
// commands, run by a small step program; depends on cdo_pkg
`default_nettype none

// Usage
//   input channel  i_in_valid / o_in_ready / i_in_data  (command beat)
//   output channel o_out_valid / i_out_ready / o_out_data (one result beat)
//   Every accepted command beat gives exactly one result beat.
//   Set and unused commands go straight to the finishing step. Query and
//   move commands run four step tests that fall through plus the finishing
//   step, Y whole 365 day years stepped (one per cycle, at most 89 for a
//   16 bit signed offset, more when OFFSET_BITS is above 16 and the offset
//   is unsigned) and M months walked after that (one per cycle, at most 12).
//   One command is worked at a time: o_in_ready is high only while the
//   sequencer is idle, so the next beat can be taken at the earliest in the
//   cycle after a result is written. The result sits in an output register,
//   so a new command can be accepted while it waits to be taken. If the
//   receiver stalls, the finishing step holds until that register is free.
//   Reset (synchronous, active low) sets the stored date to month 1, day 1,
//   year 2000 and empties the output register.
module calendar_date_offset_unit #(
    parameter int OFFSET_BITS = 16,
    parameter int YEAR_BITS   = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire cdo_pkg::t_in_beat i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output cdo_pkg::t_out_beat  o_out_data
);
    import cdo_pkg::*;

    // effective offset width as seen on the 16 bit field
    localparam int OW = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;
    localparam logic signed [ACC_W-1:0] D_YEAR  = ACC_W'(YEAR_DAYS);
    localparam logic signed [ACC_W-1:0] D_NYEAR = -ACC_W'(YEAR_DAYS);

    // stored date
    logic [MONTH_W-1:0]   r_cur_m;
    logic [DAY_W-1:0]     r_cur_d;
    logic [YEAR_BITS-1:0] r_cur_y;

    // working date of the sequencer
    logic [MONTH_W-1:0]      r_m;
    logic signed [ACC_W-1:0] r_d;
    logic [YEAR_BITS-1:0]    r_y;
    logic [2:0]              r_cmd;

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic            r_out_valid;
    t_out_beat       r_out;

    logic                    w_accept;
    logic                    w_out_free;
    t_uword                  w_uw;
    logic                    w_cond;
    logic [DAY_W-1:0]        w_len;
    logic [MONTH_W-1:0]      w_prev;
    logic signed [ACC_W-1:0] w_len_ext;
    logic signed [ACC_W-1:0] w_prev_len_ext;
    logic [OW-1:0]           w_off_raw;
    logic                    w_off_sign;
    logic signed [ACC_W-1:0] w_off_ext;
    logic signed [ACC_W-1:0] w_d_start;
    logic [DAY_W-1:0]        w_day_lim;
    logic [MONTH_W-1:0]      w_set_m;
    logic [DAY_W-1:0]        w_set_d;
    t_out_beat               w_res;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // offset: keep the low OW bits of the field, sign from its top bit when OFFSET_BITS <= OFF_W, else zero
    assign w_off_raw  = i_in_data.day_offset[OW-1:0];
    assign w_off_sign = (OFFSET_BITS <= OFF_W) ? w_off_raw[OW-1] : 1'b0;
    assign w_off_ext  = $signed({{(ACC_W-OW){w_off_sign}}, w_off_raw});
    assign w_d_start  = $signed({{(ACC_W-DAY_W){1'b0}}, r_cur_d}) + w_off_ext;

    // clamped set values
    always_comb begin
        w_day_lim = month_len(r_cur_m);
        if (i_in_data.set_value == '0) begin
            w_set_m = 4'd1;
        end else if (i_in_data.set_value > VALUE_W'(MONTHS)) begin
            w_set_m = MONTH_W'(MONTHS);
        end else begin
            w_set_m = i_in_data.set_value[MONTH_W-1:0];
        end
        if (i_in_data.set_value == '0) begin
            w_set_d = 5'd1;
        end else if (i_in_data.set_value > VALUE_W'(w_day_lim)) begin
            w_set_d = w_day_lim;
        end else begin
            w_set_d = i_in_data.set_value[DAY_W-1:0];
        end
    end

    // control word and its test
    always_comb begin
        w_uw           = ucode_rom(r_pc);
        w_len          = month_len(r_m);
        w_prev         = prev_month(r_m);
        w_len_ext      = $signed({{(ACC_W-DAY_W){1'b0}}, w_len});
        w_prev_len_ext = $signed({{(ACC_W-DAY_W){1'b0}}, month_len(w_prev)});
        case (w_uw.op)
            OP_YEAR_UP: w_cond = r_d > D_YEAR;
            OP_MON_UP:  w_cond = r_d > w_len_ext;
            OP_YEAR_DN: w_cond = r_d <= D_NYEAR;
            OP_MON_DN:  w_cond = r_d <= $signed(ACC_W'(0));
            OP_DONE:    w_cond = w_out_free;
            default:    w_cond = 1'b0;
        endcase
    end

    // result beat assembly
    always_comb begin
        w_res.stored_month = r_cur_m;
        w_res.stored_day   = r_cur_d;
        w_res.stored_year  = YOUT_W'(r_cur_y);
        w_res.other_month  = r_cur_m;
        w_res.other_day    = r_cur_d;
        w_res.other_year   = YOUT_W'(r_cur_y);
        case (r_cmd)
            CMD_QUERY: begin
                w_res.other_month = r_m;
                w_res.other_day   = r_d[DAY_W-1:0];
                w_res.other_year  = YOUT_W'(r_y);
            end
            CMD_MOVE: begin
                w_res.stored_month = r_m;
                w_res.stored_day   = r_d[DAY_W-1:0];
                w_res.stored_year  = YOUT_W'(r_y);
            end
            default: begin
            end
        endcase
    end

    // sequencer, store and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_DONE;
            r_out_valid <= 1'b0;
            r_cur_m     <= 4'd1;
            r_cur_d     <= 5'd1;
            r_cur_y     <= YEAR_BITS'(RESET_YEAR);
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                // set commands land in the store right away
                case (i_in_data.command)
                    CMD_SET_MONTH: r_cur_m <= w_set_m;
                    CMD_SET_DAY:   r_cur_d <= w_set_d;
                    CMD_SET_YEAR:  r_cur_y <= YEAR_BITS'(i_in_data.set_value);
                    default: begin
                    end
                endcase
                r_cmd  <= i_in_data.command;
                r_m    <= r_cur_m;
                r_d    <= w_d_start;
                r_y    <= r_cur_y;
                r_busy <= 1'b1;
                if (i_in_data.command == CMD_QUERY || i_in_data.command == CMD_MOVE) begin
                    r_pc <= PC_YEAR_UP;
                end else begin
                    r_pc <= PC_DONE;
                end
            end else if (r_busy) begin
                if (w_cond) begin
                    r_pc <= w_uw.jmp;
                    case (w_uw.op)
                        OP_YEAR_UP: begin
                            r_d <= r_d - D_YEAR;
                            r_y <= r_y + YEAR_BITS'(1);
                        end
                        OP_MON_UP: begin
                            r_d <= r_d - w_len_ext;
                            if (r_m == MONTH_W'(MONTHS)) begin
                                r_m <= 4'd1;
                                r_y <= r_y + YEAR_BITS'(1);
                            end else begin
                                r_m <= r_m + 4'd1;
                            end
                        end
                        OP_YEAR_DN: begin
                            r_d <= r_d + D_YEAR;
                            r_y <= r_y - YEAR_BITS'(1);
                        end
                        OP_MON_DN: begin
                            r_d <= r_d + w_prev_len_ext;
                            r_m <= w_prev;
                            if (r_m == 4'd1) begin
                                r_y <= r_y - YEAR_BITS'(1);
                            end
                        end
                        OP_DONE: begin
                            r_out       <= w_res;
                            r_out_valid <= 1'b1;
                            r_busy      <= 1'b0;
                            if (r_cmd == CMD_MOVE) begin
                                r_cur_m <= r_m;
                                r_cur_d <= r_d[DAY_W-1:0];
                                r_cur_y <= r_y;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    r_pc <= w_uw.nxt;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_calendar_date_offset_unit.sv =====
// tb_calendar_date_offset_unit: self-checking bench for the calendar date offset unit
// drives command beats, predicts each result beat and compares field by field
// depends on cdo_pkg and calendar_date_offset_unit
`timescale 1ns / 100ps

module tb_calendar_date_offset_unit;
    import cdo_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       o_in_ready;
    t_in_beat   in_data = '0;
    logic       o_out_valid;
    logic       out_ready = 1'b0;
    t_out_beat  o_out_data;

    wire in_fire  = in_valid & o_in_ready;
    wire out_fire = o_out_valid & out_ready;

    // command beats waiting to be offered, result beats waiting to arrive
    t_in_beat  pending_q[$];
    t_out_beat expected_q[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_req        = 0;
    int hold_ack        = 0;
    int hold_left       = 0;
    int mismatch_cnt    = 0;
    int idle_cycles     = 0;

    // predicted date store
    logic [MONTH_W-1:0] cal_month = 4'd1;
    logic [DAY_W-1:0]   cal_day   = 5'd1;
    logic [YOUT_W-1:0]  cal_year  = YOUT_W'(RESET_YEAR);

    calendar_date_offset_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // days per month, no leap years, out of range counts as 31
    function automatic int days_in(input int m);
        int n;
        case (m)
            2:             n = 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // stored date plus a signed day count, whole years first, then month by month
    function automatic void shift_date(input int off, output logic [MONTH_W-1:0] om,
                                       output logic [DAY_W-1:0] od,
                                       output logic [YOUT_W-1:0] oy);
        int d;
        int m;
        int y;
        int k;
        d = int'(cal_day) + off;
        m = int'(cal_month);
        y = int'(cal_year);
        if (m < 1 || m > MONTHS) begin
            m = 1;
        end
        // forward: skip whole years, then carry month by month
        if (d > YEAR_DAYS) begin
            k = (d - 1) / YEAR_DAYS;
            d = d - k * YEAR_DAYS;
            y = y + k;
        end
        while (d > days_in(m)) begin
            d = d - days_in(m);
            m = m + 1;
            if (m > MONTHS) begin
                m = 1;
                y = y + 1;
            end
        end
        // backward: skip whole years, then borrow month by month
        if (d <= -YEAR_DAYS) begin
            k = (-d) / YEAR_DAYS;
            d = d + k * YEAR_DAYS;
            y = y - k;
        end
        while (d <= 0) begin
            if (m == 1) begin
                m = MONTHS + 1;
                y = y - 1;
            end
            d = d + days_in(m - 1);
            m = m - 1;
        end
        om = m[MONTH_W-1:0];
        od = d[DAY_W-1:0];
        oy = y[YOUT_W-1:0];
    endfunction

    // apply one command beat to the predicted store, return its result beat
    function automatic t_out_beat advance_date(input t_in_beat beat);
        t_out_beat res;
        int v;
        int lim;
        int off;
        logic [MONTH_W-1:0] nm;
        logic [DAY_W-1:0]   nd;
        logic [YOUT_W-1:0]  ny;
        v   = int'(beat.set_value);
        off = int'($signed(beat.day_offset));
        case (beat.command)
            CMD_SET_MONTH: begin
                if (v == 0) v = 1;
                if (v > MONTHS) v = MONTHS;
                cal_month = v[MONTH_W-1:0];
            end
            CMD_SET_DAY: begin
                lim = days_in(int'(cal_month));
                if (v == 0) v = 1;
                if (v > lim) v = lim;
                cal_day = v[DAY_W-1:0];
            end
            CMD_SET_YEAR: begin
                cal_year = beat.set_value;
            end
            default: begin
            end
        endcase
        res.other_month = cal_month;
        res.other_day   = cal_day;
        res.other_year  = cal_year;
        if (beat.command == CMD_QUERY) begin
            shift_date(off, nm, nd, ny);
            res.other_month = nm;
            res.other_day   = nd;
            res.other_year  = ny;
        end else if (beat.command == CMD_MOVE) begin
            shift_date(off, nm, nd, ny);
            cal_month = nm;
            cal_day   = nd;
            cal_year  = ny;
        end
        res.stored_month = cal_month;
        res.stored_day   = cal_day;
        res.stored_year  = cal_year;
        return res;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    function automatic t_in_beat make_beat(input logic [2:0] cmd, input int val, input int off);
        t_in_beat b;
        b.command    = cmd;
        b.set_value  = val[VALUE_W-1:0];
        b.day_offset = off[OFF_W-1:0];
        return b;
    endfunction

    // random beat: mostly queries and moves, some sets, a little noise
    function automatic t_in_beat random_beat();
        int r;
        int sel;
        int off;
        int val;
        logic [2:0] cmd;
        r   = $urandom_range(0, 99);
        val = $urandom_range(0, 65535);
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            off = $urandom_range(0, 400);
        end else if (sel < 7) begin
            off = $urandom_range(0, 3000);
        end else begin
            off = $urandom_range(0, 65535);
        end
        if (sel < 7 && $urandom_range(0, 1) == 1) begin
            off = -off;
        end
        if (r < 12) begin
            cmd = CMD_SET_MONTH;
            if ($urandom_range(0, 3) != 0) val = $urandom_range(0, 15);
        end else if (r < 24) begin
            cmd = CMD_SET_DAY;
            if ($urandom_range(0, 3) != 0) val = $urandom_range(0, 35);
        end else if (r < 32) begin
            cmd = CMD_SET_YEAR;
        end else if (r < 62) begin
            cmd = CMD_QUERY;
        end else if (r < 92) begin
            cmd = CMD_MOVE;
        end else begin
            cmd = 3'($urandom_range(5, 7));
        end
        return make_beat(cmd, val, off);
    endfunction

    // driver: offers queued beats, predicts each accepted one
    always @(posedge i_clk) begin : drive_proc
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            cal_month = 4'd1;
            cal_day   = 5'd1;
            cal_year  = YOUT_W'(RESET_YEAR);
        end else begin
            if (in_fire) begin
                expected_q.push_back(advance_date(in_data));
            end
            if (!in_valid || in_fire) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    in_data  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks result beats and drives ready, with a long hold-off on request
    always @(posedge i_clk) begin : sink_proc
        t_out_beat exp_b;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_fire) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no expected result");
                    mismatch_cnt++;
                end else begin
                    exp_b = expected_q.pop_front();
                    check_field("stored_month", exp_b.stored_month, o_out_data.stored_month);
                    check_field("stored_day", exp_b.stored_day, o_out_data.stored_day);
                    check_field("stored_year", exp_b.stored_year, o_out_data.stored_year);
                    check_field("other_month", exp_b.other_month, o_out_data.other_month);
                    check_field("other_day", exp_b.other_day, o_out_data.other_day);
                    check_field("other_year", exp_b.other_year, o_out_data.other_year);
                end
            end
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire || out_fire) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // wait until every queued beat is sent and every result has come back
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic random_phase(input int sidle, input int rstall, input int count);
        sender_idle_pct = sidle;
        recv_stall_pct  = rstall;
        repeat (count) pending_q.push_back(random_beat());
        drain();
    endtask

    // stimulus
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: clamps, feb 31, year wrap both ways, extreme offsets, unused commands
        pending_q.push_back(make_beat(CMD_QUERY, 0, 0));
        pending_q.push_back(make_beat(CMD_SET_MONTH, 0, 0));
        pending_q.push_back(make_beat(CMD_SET_MONTH, 13, 0));
        pending_q.push_back(make_beat(CMD_SET_MONTH, 65535, -1));
        pending_q.push_back(make_beat(CMD_SET_DAY, 0, 0));
        pending_q.push_back(make_beat(CMD_SET_DAY, 65535, 0));
        pending_q.push_back(make_beat(CMD_SET_MONTH, 2, 0));
        pending_q.push_back(make_beat(CMD_QUERY, 0, 0));
        pending_q.push_back(make_beat(CMD_MOVE, 65535, 0));
        pending_q.push_back(make_beat(CMD_SET_DAY, 31, 0));
        pending_q.push_back(make_beat(CMD_SET_YEAR, 0, 0));
        pending_q.push_back(make_beat(CMD_SET_MONTH, 1, 0));
        pending_q.push_back(make_beat(CMD_SET_DAY, 1, 0));
        pending_q.push_back(make_beat(CMD_QUERY, 0, -1));
        pending_q.push_back(make_beat(CMD_SET_YEAR, 65535, 0));
        pending_q.push_back(make_beat(CMD_SET_MONTH, 12, 0));
        pending_q.push_back(make_beat(CMD_SET_DAY, 31, 0));
        pending_q.push_back(make_beat(CMD_QUERY, 0, 1));
        pending_q.push_back(make_beat(CMD_QUERY, 0, 32767));
        pending_q.push_back(make_beat(CMD_QUERY, 0, -32768));
        pending_q.push_back(make_beat(CMD_MOVE, 0, 32767));
        pending_q.push_back(make_beat(CMD_MOVE, 0, -32768));
        pending_q.push_back(make_beat(3'd5, 65535, -1));
        pending_q.push_back(make_beat(3'd6, 21845, 21845));
        pending_q.push_back(make_beat(3'd7, 43690, -21846));
        drain();

        // random phases with different idling
        random_phase(0, 0, 110);
        random_phase(54, 0, 110);
        random_phase(0, 54, 110);
        random_phase(34, 34, 110);

        // long receiver hold-off while the sender keeps offering
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req = hold_req + 1;
        repeat (60) pending_q.push_back(random_beat());
        drain();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
